>>> rtl/core/mcfm_pkg.sv
// ----------------------------------------------------------------------------
// mcfm_pkg
// Shared types and constants for the motor current fault monitor.
// ----------------------------------------------------------------------------
package mcfm_pkg;

  // Averager
  localparam int SAMPLE_BITS   = 12;
  localparam int AVG_FRAC_BITS = 8;
  localparam int ALPHA_SHIFT   = 2;
  localparam int AVG_W         = SAMPLE_BITS + AVG_FRAC_BITS;

  // Evaluation arithmetic
  localparam int DUTY_W     = 15;
  localparam int MAG_W      = 15;
  localparam int MIN_DUTY_W = 14;
  localparam int LEVEL_W    = 16;
  localparam int TIME_W     = 16;
  localparam int NOW_W      = 32;
  localparam int MUL_W      = 16;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int NUM_W      = 26;
  localparam int REM_W      = MAG_W + 1;
  localparam int DIV_STEPS  = NUM_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam logic [MUL_W-1:0] FULL_DUTY = MUL_W'(10000);

  // Fault windows
  localparam int N_WIN     = 3;
  localparam int WIN_IDX_W = 2;
  localparam logic [WIN_IDX_W-1:0] WIN_SHORT = 2'd0;
  localparam logic [WIN_IDX_W-1:0] WIN_OPEN  = 2'd1;
  localparam logic [WIN_IDX_W-1:0] WIN_STALL = 2'd2;

  // Ports
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE     = 3'd0,
    REG_MIN_DUTY   = 3'd1,
    REG_SHORT_LVL  = 3'd2,
    REG_SHORT_TIME = 3'd3,
    REG_OPEN_LVL   = 3'd4,
    REG_OPEN_TIME  = 3'd5,
    REG_STALL_LVL  = 3'd6,
    REG_STALL_TIME = 3'd7
  } cfg_idx_t;

  localparam logic [MIN_DUTY_W-1:0] RST_MIN_DUTY   = 14'd500;
  localparam logic [LEVEL_W-1:0]    RST_SHORT_LVL  = 16'd4000;
  localparam logic [TIME_W-1:0]     RST_SHORT_TIME = 16'd50;
  localparam logic [LEVEL_W-1:0]    RST_OPEN_LVL   = 16'd20;
  localparam logic [TIME_W-1:0]     RST_OPEN_TIME  = 16'd500;
  localparam logic [LEVEL_W-1:0]    RST_STALL_LVL  = 16'd3000;
  localparam logic [TIME_W-1:0]     RST_STALL_TIME = 16'd1000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SAMPLE,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_CMP,
    ST_WIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                 cap;
    logic                 avg_upd;
    logic                 clr_cond;
    logic                 mul_num;
    logic                 div_step;
    logic                 cmp_mul;
    logic                 win_upd;
    logic                 out_load;
    logic [WIN_IDX_W-1:0] win_idx;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic evaluable;
  } status_t;

endpackage

>>> rtl/core/motor_current_fault_monitor.sv
// ----------------------------------------------------------------------------
// motor_current_fault_monitor
// Averages current samples and flags short, open and stall faults.
// ----------------------------------------------------------------------------
// Steps: a sample beat is captured, checked, averaged and loaded as a result;
//   an evaluate beat is captured and checked, then, when not evaluable, has
//   estimate, flags and windows cleared and its result loaded, else goes through
//   multiply, 26-step serial divide, three multiply-compare/window pairs and
//   result load. Flow: one beat at a time. A finished result waits in the
//   output register while the next beat is taken.
// Reset (rst_n, synchronous): registers to defaults, average unprimed,
//   estimate, flags and windows clear, no result pending.
// ----------------------------------------------------------------------------
module motor_current_fault_monitor (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [11:0] sample, [43:12] now_ms, [58:44] duty, [63:59] zero
  input  logic [mcfm_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [0] mode
  input  logic [0:0]                           in_tuser,
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [11:0] filtered_level, [37:12] normalized_level, [38] short_fault,
  // [39] open_fault, [40] stall_fault, [47:41] zero
  output logic [mcfm_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // configuration
  input  logic                                 cfg_we,
  input  logic [mcfm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mcfm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  mcfm_pkg::cmd_t    cmd;
  mcfm_pkg::status_t sts;

  // Sequencer: one beat in flight; the handshake lives here.
  mcfm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Datapath: config registers, averager, multiplier, divider, windows.
  mcfm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser[0]),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

>>> rtl/core/mcfm_ctrl.sv
// ----------------------------------------------------------------------------
// mcfm_ctrl
// Sequencer: steps the datapath through averaging or fault evaluation.
// ----------------------------------------------------------------------------
module mcfm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  mcfm_pkg::status_t sts,
  output mcfm_pkg::cmd_t    cmd
);

  mcfm_pkg::state_t             state_r, state_nxt;
  logic [mcfm_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mcfm_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.win_idx = cnt_r[mcfm_pkg::WIN_IDX_W-1:0];
    in_tready = (state_r == mcfm_pkg::ST_IDLE);
    case (state_r)
      mcfm_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd.cap = 1'b1;
          state_nxt = mcfm_pkg::ST_CHECK;
        end
      end
      mcfm_pkg::ST_CHECK: begin
        // captured item is now visible on status
        if (!sts.mode) begin
          state_nxt = mcfm_pkg::ST_SAMPLE;
        end else if (!sts.evaluable) begin
          cmd.clr_cond = 1'b1;
          state_nxt = mcfm_pkg::ST_DONE;
        end else begin
          state_nxt = mcfm_pkg::ST_MUL;
        end
      end
      mcfm_pkg::ST_SAMPLE: begin
        cmd.avg_upd = 1'b1;
        state_nxt = mcfm_pkg::ST_DONE;
      end
      mcfm_pkg::ST_MUL: begin
        cmd.mul_num = 1'b1;
        cnt_nxt = '0;
        state_nxt = mcfm_pkg::ST_DIV;
      end
      mcfm_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == mcfm_pkg::CNT_W'(mcfm_pkg::DIV_STEPS - 1)) begin
          cnt_nxt = '0;
          state_nxt = mcfm_pkg::ST_CMP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      mcfm_pkg::ST_CMP: begin
        cmd.cmp_mul = 1'b1;
        state_nxt = mcfm_pkg::ST_WIN;
      end
      mcfm_pkg::ST_WIN: begin
        cmd.win_upd = 1'b1;
        if (cnt_r == mcfm_pkg::CNT_W'(mcfm_pkg::N_WIN - 1)) begin
          cnt_nxt = '0;
          state_nxt = mcfm_pkg::ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          state_nxt = mcfm_pkg::ST_CMP;
        end
      end
      mcfm_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt = mcfm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mcfm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (cmd.out_load)              out_valid_nxt = 1'b1;
  end

  assign out_tvalid = out_valid_r;

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mcfm_pkg::ST_DIV) |-> (cnt_r <= mcfm_pkg::CNT_W'(mcfm_pkg::DIV_STEPS - 1)))
    else $error("divider step count overran");

  a_win_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mcfm_pkg::ST_CMP || state_r == mcfm_pkg::ST_WIN)
      |-> (cnt_r < mcfm_pkg::CNT_W'(mcfm_pkg::N_WIN)))
    else $error("window index out of range");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");

  a_accept_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == mcfm_pkg::ST_CHECK))
    else $error("accepted beat not taken into work");

endmodule

>>> rtl/core/mcfm_dp.sv
// ----------------------------------------------------------------------------
// mcfm_dp
// Datapath: config registers, averager, shared multiplier, serial divider,
// fault windows and result register.
// ----------------------------------------------------------------------------
module mcfm_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [mcfm_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tuser,
  output logic [mcfm_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_we,
  input  logic [mcfm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mcfm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  mcfm_pkg::cmd_t                      cmd,
  output mcfm_pkg::status_t                   sts
);

  localparam int HALF_LSB = 1 << (mcfm_pkg::AVG_FRAC_BITS - 1);
  localparam int ALPHA_M  = (1 << mcfm_pkg::ALPHA_SHIFT) - 1;

  // configuration
  logic                                enable_r;
  logic [mcfm_pkg::MIN_DUTY_W-1:0]     min_duty_r;
  logic [mcfm_pkg::LEVEL_W-1:0]        lvl_r  [mcfm_pkg::N_WIN];
  logic [mcfm_pkg::TIME_W-1:0]         tim_r  [mcfm_pkg::N_WIN];

  // captured item
  logic                                mode_r;
  logic [mcfm_pkg::SAMPLE_BITS-1:0]    sample_r;
  logic [mcfm_pkg::NOW_W-1:0]          now_r;
  logic [mcfm_pkg::MAG_W-1:0]          mag_r;

  // state
  logic [mcfm_pkg::AVG_W-1:0]          avg_r, avg_nxt;
  logic                                primed_r, primed_nxt;
  logic [mcfm_pkg::NUM_W-1:0]          est_r, est_nxt;
  logic [mcfm_pkg::N_WIN-1:0]          flags_r, flags_nxt;
  logic [mcfm_pkg::N_WIN-1:0]          active_r, active_nxt;
  logic [mcfm_pkg::NOW_W-1:0]          start_r [mcfm_pkg::N_WIN];

  // arithmetic
  logic [mcfm_pkg::NUM_W-1:0]          num_r;
  logic [mcfm_pkg::NUM_W-1:0]          quo_r, quo_nxt;
  logic [mcfm_pkg::REM_W-1:0]          rem_r, rem_nxt;
  logic [mcfm_pkg::PROD_W-1:0]         prod_r;
  logic [mcfm_pkg::OUT_TDATA_W-1:0]    out_r;

  logic [mcfm_pkg::DUTY_W-1:0]         duty_in;
  logic [mcfm_pkg::MAG_W-1:0]          mag_in;
  logic [mcfm_pkg::AVG_W:0]            round_sum;
  logic [mcfm_pkg::SAMPLE_BITS-1:0]    level;
  logic [mcfm_pkg::AVG_W-1:0]          x_fix;
  logic [mcfm_pkg::AVG_W:0]            dn_sum;
  logic [mcfm_pkg::MUL_W-1:0]          mul_a, mul_b;
  logic [mcfm_pkg::PROD_W-1:0]         mul_p;
  logic [mcfm_pkg::REM_W-1:0]          rem_sh;
  logic                                cond;
  logic [mcfm_pkg::NOW_W-1:0]          elapsed;

  // --- configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b1;
      min_duty_r <= mcfm_pkg::RST_MIN_DUTY;
      lvl_r[0]   <= mcfm_pkg::RST_SHORT_LVL;
      tim_r[0]   <= mcfm_pkg::RST_SHORT_TIME;
      lvl_r[1]   <= mcfm_pkg::RST_OPEN_LVL;
      tim_r[1]   <= mcfm_pkg::RST_OPEN_TIME;
      lvl_r[2]   <= mcfm_pkg::RST_STALL_LVL;
      tim_r[2]   <= mcfm_pkg::RST_STALL_TIME;
    end else if (cfg_we) begin
      case (mcfm_pkg::cfg_idx_t'(cfg_index))
        mcfm_pkg::REG_ENABLE:     enable_r   <= cfg_wdata[0];
        mcfm_pkg::REG_MIN_DUTY:   min_duty_r <= cfg_wdata[mcfm_pkg::MIN_DUTY_W-1:0];
        mcfm_pkg::REG_SHORT_LVL:  lvl_r[0]   <= cfg_wdata;
        mcfm_pkg::REG_SHORT_TIME: tim_r[0]   <= cfg_wdata;
        mcfm_pkg::REG_OPEN_LVL:   lvl_r[1]   <= cfg_wdata;
        mcfm_pkg::REG_OPEN_TIME:  tim_r[1]   <= cfg_wdata;
        mcfm_pkg::REG_STALL_LVL:  lvl_r[2]   <= cfg_wdata;
        mcfm_pkg::REG_STALL_TIME: tim_r[2]   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --- capture; duty magnitude folded in on the way
  assign duty_in = in_tdata[58:44];
  assign mag_in  = duty_in[mcfm_pkg::DUTY_W-1] ? (~duty_in + 1'b1) : duty_in;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      mode_r   <= in_tuser;
      sample_r <= in_tdata[11:0];
      now_r    <= in_tdata[43:12];
      mag_r    <= mag_in;
    end
  end

  assign sts.mode      = mode_r;
  assign sts.evaluable = enable_r && (mag_r >= {1'b0, min_duty_r}) && (mag_r != '0);

  // --- rounded average
  assign round_sum = {1'b0, avg_r} + (mcfm_pkg::AVG_W + 1)'(HALF_LSB);
  assign level     = round_sum[mcfm_pkg::AVG_W-1:mcfm_pkg::AVG_FRAC_BITS];

  // --- averager
  assign x_fix  = {sample_r, {mcfm_pkg::AVG_FRAC_BITS{1'b0}}};
  assign dn_sum = {1'b0, avg_r - x_fix} + (mcfm_pkg::AVG_W + 1)'(ALPHA_M);

  always_comb begin
    avg_nxt    = avg_r;
    primed_nxt = primed_r;
    if (cmd.avg_upd) begin
      primed_nxt = 1'b1;
      if (!primed_r)
        avg_nxt = x_fix;
      else if (x_fix >= avg_r)
        avg_nxt = avg_r + ((x_fix - avg_r) >> mcfm_pkg::ALPHA_SHIFT);
      else
        avg_nxt = avg_r - mcfm_pkg::AVG_W'(dn_sum >> mcfm_pkg::ALPHA_SHIFT);
    end
  end

  // --- shared multiplier, registered product
  always_comb begin
    if (cmd.mul_num) begin
      mul_a = mcfm_pkg::MUL_W'(level);
      mul_b = mcfm_pkg::FULL_DUTY;
    end else begin
      mul_a = lvl_r[cmd.win_idx];
      mul_b = mcfm_pkg::MUL_W'(mag_r);
    end
  end
  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_num) num_r  <= mul_p[mcfm_pkg::NUM_W-1:0];
    if (cmd.cmp_mul) prod_r <= mul_p;
  end

  // --- restoring divider, one quotient bit a step
  assign rem_sh = {rem_r[mcfm_pkg::REM_W-2:0], quo_r[mcfm_pkg::NUM_W-1]};

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    if (cmd.mul_num) begin
      quo_nxt = mul_p[mcfm_pkg::NUM_W-1:0];
      rem_nxt = '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, mag_r}) begin
        rem_nxt = rem_sh - {1'b0, mag_r};
        quo_nxt = {quo_r[mcfm_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[mcfm_pkg::NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  // --- fault windows; open is a low-side test
  assign cond = (cmd.win_idx == mcfm_pkg::WIN_OPEN)
              ? (mcfm_pkg::PROD_W'(num_r) <= prod_r)
              : (mcfm_pkg::PROD_W'(num_r) >= prod_r);
  assign elapsed = now_r - (active_r[cmd.win_idx] ? start_r[cmd.win_idx] : now_r);

  always_comb begin
    est_nxt    = est_r;
    flags_nxt  = flags_r;
    active_nxt = active_r;
    if (cmd.clr_cond) begin
      est_nxt    = '0;
      flags_nxt  = '0;
      active_nxt = '0;
    end
    if (cmd.cmp_mul) est_nxt = quo_r;
    if (cmd.win_upd) begin
      active_nxt[cmd.win_idx] = cond;
      flags_nxt[cmd.win_idx]  = cond &&
        (elapsed >= mcfm_pkg::NOW_W'(tim_r[cmd.win_idx]));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win_upd && cond && !active_r[cmd.win_idx])
      start_r[cmd.win_idx] <= now_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r    <= '0;
      primed_r <= 1'b0;
      est_r    <= '0;
      flags_r  <= '0;
      active_r <= '0;
    end else begin
      avg_r    <= avg_nxt;
      primed_r <= primed_nxt;
      est_r    <= est_nxt;
      flags_r  <= flags_nxt;
      active_r <= active_nxt;
    end
  end

  // --- result register
  always_ff @(posedge clk) begin
    if (cmd.out_load)
      out_r <= {7'd0, flags_r[mcfm_pkg::WIN_STALL], flags_r[mcfm_pkg::WIN_OPEN],
                flags_r[mcfm_pkg::WIN_SHORT], est_r, level};
  end

  assign out_tdata = out_r;

  a_flag_needs_window: assert property (@(posedge clk) disable iff (!rst_n)
    (flags_r & ~active_r) == '0)
    else $error("fault flag set with idle window");

  a_est_needs_primed: assert property (@(posedge clk) disable iff (!rst_n)
    (est_r != '0) |-> primed_r)
    else $error("estimate without any sample");

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for motor_current_fault_monitor. A shadow model of the
// current averager, duty normaliser and fault windows predicts every result
// beat; the monitor compares each one field by field. Both streams stall at
// random in all but the last phase; the registers are reprogrammed between runs.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mcfm_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 7;
  // Worst quiet stretch of a good run: an evaluate with divide plus a long run of
  // receiver stalls at 79 %, or an eight-write register update. Taken many times.
  localparam int WATCHDOG_LIMIT = 5000;
  // Longest path through the block is an evaluate with divide.
  localparam int SETTLE_CYCLES  = 40;
  localparam int RUN_BEATS      = 103;
  localparam int MAX_REPORTS    = 25;
  localparam int N_REGS         = 8;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_EVAL   = 1'b1;

  // Full-duty scale, 0.01 % units
  localparam longint FULL_SCALE = 10000;
  localparam longint EST_CEIL   = (longint'(1) << NUM_W) - 1;

  // Result beat layout, lowest bit first
  localparam int FILT_LSB  = 0;
  localparam int NORM_LSB  = FILT_LSB + SAMPLE_BITS;
  localparam int FAULT_LSB = NORM_LSB + NUM_W;

  // Idle percentages per stimulus phase: sender, then receiver
  localparam int SEND_GAP [3] = '{38, 79, 0};
  localparam int TAKE_GAP [3] = '{79, 38, 0};

  typedef struct {
    logic                     mode;
    logic [SAMPLE_BITS-1:0]   sample;
    logic [NOW_W-1:0]         now_ms;
    logic signed [DUTY_W-1:0] duty;
  } beat_t;

  typedef struct {
    logic [SAMPLE_BITS-1:0] filtered;
    logic [NUM_W-1:0]       normalized;
    logic [N_WIN-1:0]       faults;     // indexed by WIN_SHORT/WIN_OPEN/WIN_STALL
  } reading_t;

  typedef enum {
    SET_DEFAULT,
    SET_RANDOM,
    SET_FLOOR,
    SET_CEILING,
    SET_DISABLED
  } reg_setting_t;

  // Block ports, inputs all known from time zero
  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // [11:0] sample, [43:12] now_ms, [58:44] duty, [63:59] zero
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  // [0] mode
  logic [0:0]             in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [11:0] filtered_level, [37:12] normalized_level, [38] short_fault,
  // [39] open_fault, [40] stall_fault, [47:41] zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  // Stimulus and expectation stores
  beat_t    beats_to_send [$];
  reading_t readings_due  [$];
  beat_t    beat_on_bus;

  int send_gap_pct = 0;
  int take_gap_pct = 0;
  int mismatches   = 0;
  int quiet_cycles = 0;

  // Random-run shaping: a wandering current level and a mostly rising clock
  int               level_aim;
  logic [NOW_W-1:0] clock_ms;

  // Shadow copy of the block: registers, averager, estimate and windows
  logic [CFG_DATA_W-1:0] reg_copy [N_REGS];
  logic [AVG_W-1:0]      avg_fix;       // Q12.8
  logic                  avg_primed;
  logic [NUM_W-1:0]      est_level;
  logic [N_WIN-1:0]      fault_q;
  logic [N_WIN-1:0]      window_open;
  logic [NOW_W-1:0]      window_t0 [N_WIN];

  motor_current_fault_monitor u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Shadow model
  // --------------------------------------------------------------------------
  task automatic reset_fault_model();
    reg_copy[REG_ENABLE]     = 16'd1;
    reg_copy[REG_MIN_DUTY]   = CFG_DATA_W'(RST_MIN_DUTY);
    reg_copy[REG_SHORT_LVL]  = RST_SHORT_LVL;
    reg_copy[REG_SHORT_TIME] = RST_SHORT_TIME;
    reg_copy[REG_OPEN_LVL]   = RST_OPEN_LVL;
    reg_copy[REG_OPEN_TIME]  = RST_OPEN_TIME;
    reg_copy[REG_STALL_LVL]  = RST_STALL_LVL;
    reg_copy[REG_STALL_TIME] = RST_STALL_TIME;
    avg_fix     = '0;
    avg_primed  = 1'b0;
    est_level   = '0;
    fault_q     = '0;
    window_open = '0;
    for (int k = 0; k < N_WIN; k++) window_t0[k] = '0;
  endtask

  // Average rounded to the nearest whole count
  function automatic logic [SAMPLE_BITS-1:0] rounded_level();
    return SAMPLE_BITS'((int'(avg_fix) + (1 << (AVG_FRAC_BITS - 1))) >> AVG_FRAC_BITS);
  endfunction

  // One persistence window: flag once the condition has held for span ms,
  // elapsed time taken modulo 2^32 so the window survives a clock wrap.
  task automatic step_window(input int k, input logic holds, input logic [NOW_W-1:0] now,
                             input logic [CFG_DATA_W-1:0] span);
    logic [NOW_W-1:0] elapsed;
    if (!holds) begin
      window_open[k] = 1'b0;
      fault_q[k]     = 1'b0;
    end else begin
      if (!window_open[k]) begin
        window_open[k] = 1'b1;
        window_t0[k]   = now;
      end
      elapsed    = now - window_t0[k];
      fault_q[k] = (elapsed >= NOW_W'(span));
    end
  endtask

  task automatic update_fault_model(input beat_t b, output reading_t r);
    logic [AVG_W-1:0] x;
    logic [AVG_W-1:0] gap;
    longint           mag;
    longint           num;
    longint           q;
    if (b.mode == MODE_SAMPLE) begin
      x = AVG_W'(b.sample) << AVG_FRAC_BITS;
      if (!avg_primed) begin
        avg_fix    = x;
        avg_primed = 1'b1;
      end else if (x >= avg_fix) begin
        gap     = x - avg_fix;
        avg_fix = avg_fix + (gap >> ALPHA_SHIFT);
      end else begin
        // falling step is floored, so its magnitude rounds up
        gap     = avg_fix - x;
        avg_fix = avg_fix - AVG_W'((int'(gap) + (1 << ALPHA_SHIFT) - 1) >> ALPHA_SHIFT);
      end
    end else begin
      mag = (b.duty < 0) ? -longint'(b.duty) : longint'(b.duty);
      if (reg_copy[REG_ENABLE] == '0 || mag < longint'(reg_copy[REG_MIN_DUTY]) || mag == 0)
      begin
        // not evaluable: window start times are kept
        est_level   = '0;
        fault_q     = '0;
        window_open = '0;
      end else begin
        num       = longint'(rounded_level()) * FULL_SCALE;
        q         = num / mag;
        est_level = (q > EST_CEIL) ? NUM_W'(EST_CEIL) : NUM_W'(q);
        // thresholds compared by cross-multiplication, no rounding
        step_window(int'(WIN_SHORT), num >= longint'(reg_copy[REG_SHORT_LVL]) * mag,
                    b.now_ms, reg_copy[REG_SHORT_TIME]);
        step_window(int'(WIN_OPEN), num <= longint'(reg_copy[REG_OPEN_LVL]) * mag,
                    b.now_ms, reg_copy[REG_OPEN_TIME]);
        step_window(int'(WIN_STALL), num >= longint'(reg_copy[REG_STALL_LVL]) * mag,
                    b.now_ms, reg_copy[REG_STALL_TIME]);
      end
    end
    r.filtered   = rounded_level();
    r.normalized = est_level;
    r.faults     = fault_q;
  endtask

  // --------------------------------------------------------------------------
  // Register writes, only ever issued while the block is idle
  // --------------------------------------------------------------------------
  task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    // bits above a register's width are dropped by the block
    case (idx)
      REG_ENABLE:   reg_copy[idx] = value & 16'h0001;
      REG_MIN_DUTY: reg_copy[idx] = value & CFG_DATA_W'((1 << MIN_DUTY_W) - 1);
      default:      reg_copy[idx] = value;
    endcase
  endtask

  task automatic programme_registers(input reg_setting_t kind);
    logic [CFG_DATA_W-1:0] v [N_REGS];
    case (kind)
      SET_DEFAULT: begin
        v[REG_ENABLE]     = 16'd1;
        v[REG_MIN_DUTY]   = CFG_DATA_W'(RST_MIN_DUTY);
        v[REG_SHORT_LVL]  = RST_SHORT_LVL;
        v[REG_SHORT_TIME] = RST_SHORT_TIME;
        v[REG_OPEN_LVL]   = RST_OPEN_LVL;
        v[REG_OPEN_TIME]  = RST_OPEN_TIME;
        v[REG_STALL_LVL]  = RST_STALL_LVL;
        v[REG_STALL_TIME] = RST_STALL_TIME;
      end
      SET_FLOOR: begin
        // every threshold and time at zero: short and stall flag at once
        for (int i = 0; i < N_REGS; i++) v[i] = '0;
        v[REG_ENABLE] = 16'd1;
      end
      SET_CEILING: begin
        // enable and min duty see their upper bits masked off
        for (int i = 0; i < N_REGS; i++) v[i] = '1;
      end
      default: begin
        v[REG_ENABLE]     = {15'($urandom), kind == SET_RANDOM};
        v[REG_MIN_DUTY]   = {2'($urandom), 14'($urandom_range(3000))};
        v[REG_SHORT_LVL]  = CFG_DATA_W'($urandom_range(12000));
        v[REG_SHORT_TIME] = CFG_DATA_W'($urandom_range(1500));
        v[REG_OPEN_LVL]   = CFG_DATA_W'($urandom_range(12000));
        v[REG_OPEN_TIME]  = CFG_DATA_W'($urandom_range(1500));
        v[REG_STALL_LVL]  = CFG_DATA_W'($urandom_range(12000));
        v[REG_STALL_TIME] = CFG_DATA_W'($urandom_range(1500));
      end
    endcase
    for (int i = 0; i < N_REGS; i++) write_register(cfg_idx_t'(i), v[i]);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus builders; unused fields of a beat carry random filler
  // --------------------------------------------------------------------------
  task automatic queue_sample(input int value);
    beat_t b;
    b.mode   = MODE_SAMPLE;
    b.sample = SAMPLE_BITS'(value);
    b.now_ms = $urandom;
    b.duty   = DUTY_W'($urandom);
    beats_to_send.push_back(b);
  endtask

  task automatic queue_eval(input logic [NOW_W-1:0] now, input int duty);
    beat_t b;
    b.mode   = MODE_EVAL;
    b.sample = SAMPLE_BITS'($urandom);
    b.now_ms = now;
    b.duty   = DUTY_W'(duty);
    beats_to_send.push_back(b);
  endtask

  // Mostly coherent traffic: samples around a slowly moving level, evaluations
  // with a rising clock and usable duty, so that windows get time to mature.
  // A small share is pure noise (random mode, time and duty).
  task automatic queue_random_run(input int count);
    int pick;
    int value;
    int mag;
    int floor_mag;
    floor_mag = int'(reg_copy[REG_MIN_DUTY]);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(39) == 0)
        level_aim = ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(4095);
      pick = $urandom_range(99);
      if (pick < 8) begin
        beats_to_send.push_back('{mode: 1'($urandom), sample: SAMPLE_BITS'($urandom),
                                  now_ms: $urandom, duty: DUTY_W'($urandom)});
      end else if (pick < 55) begin
        value = level_aim + int'($urandom_range(64)) - 32;
        if (value < 0) value = 0;
        if (value > 4095) value = 4095;
        queue_sample(value);
      end else begin
        if ($urandom_range(24) == 0) clock_ms = clock_ms + $urandom;
        else clock_ms = clock_ms + $urandom_range(120);
        pick = $urandom_range(99);
        if (pick < 5) mag = 0;
        else if (pick < 15) mag = $urandom_range(floor_mag, 0);
        else mag = $urandom_range(10000, floor_mag);
        if (pick >= 95) queue_eval(clock_ms, int'($urandom_range(32767)));
        else queue_eval(clock_ms, $urandom_range(1) ? -mag : mag);
      end
    end
  endtask

  // Sender holds off until every result owed has been taken
  task automatic wait_for_readings();
    do @(negedge clk);
    while (beats_to_send.size() != 0 || in_tvalid || readings_due.size() != 0);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Driver: predicts on every accepted beat, then offers the next one
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    reading_t due;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        update_fault_model(beat_on_bus, due);
        readings_due.push_back(due);
      end
      // bus free after this edge: offer a beat or idle
      if (!in_tvalid || in_tready) begin
        if (beats_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          beat_on_bus = beats_to_send.pop_front();
          in_tvalid  <= 1'b1;
          in_tdata   <= IN_TDATA_W'({beat_on_bus.duty, beat_on_bus.now_ms, beat_on_bus.sample});
          in_tuser   <= beat_on_bus.mode;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random back-pressure, each result beat checked against the oldest
  // reading owed
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    reading_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (readings_due.size() == 0) begin
          report_mismatch("unrequested result beat", longint'(out_tdata), 0);
        end else begin
          want = readings_due.pop_front();
          if (out_tdata[FILT_LSB +: SAMPLE_BITS] !== want.filtered)
            report_mismatch("filtered_level", out_tdata[FILT_LSB +: SAMPLE_BITS],
                            want.filtered);
          if (out_tdata[NORM_LSB +: NUM_W] !== want.normalized)
            report_mismatch("normalized_level", out_tdata[NORM_LSB +: NUM_W],
                            want.normalized);
          if (out_tdata[FAULT_LSB + WIN_SHORT] !== want.faults[WIN_SHORT])
            report_mismatch("short_fault", out_tdata[FAULT_LSB + WIN_SHORT],
                            want.faults[WIN_SHORT]);
          if (out_tdata[FAULT_LSB + WIN_OPEN] !== want.faults[WIN_OPEN])
            report_mismatch("open_fault", out_tdata[FAULT_LSB + WIN_OPEN],
                            want.faults[WIN_OPEN]);
          if (out_tdata[FAULT_LSB + WIN_STALL] !== want.faults[WIN_STALL])
            report_mismatch("stall_fault", out_tdata[FAULT_LSB + WIN_STALL],
                            want.faults[WIN_STALL]);
        end
      end
      out_tready <= ($urandom_range(99) >= take_gap_pct);
    end
  end

  // Watchdog: too long without a beat on either stream means a hang
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: directed beats on reset settings, then three phases of random
  // runs at differing idle rates, registers reprogrammed before each run
  // --------------------------------------------------------------------------
  initial begin
    reset_fault_model();
    clock_ms     = $urandom;
    level_aim    = 2048;
    send_gap_pct = SEND_GAP[0];
    take_gap_pct = TAKE_GAP[0];
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, on the reset register values
    queue_eval(32'd1000, 5000);          // before any sample: level 0, open window starts
    queue_eval(32'd1600, -5000);         // open held 600 ms, flags
    queue_sample(4095);                  // first sample loads the average outright
    queue_eval(32'd1700, 10000);         // short and stall windows start, open clears
    queue_eval(32'd1760, -10000);        // short held 60 ms
    queue_eval(32'd2700, 10000);         // stall held exactly its 1000 ms
    queue_eval(32'd2701, 499);           // one below min duty: all clear
    queue_eval(32'd2702, 500);           // at min duty, large estimate
    queue_eval(32'd2800, 0);             // zero duty
    queue_eval(32'hFFFF_FFE0, 10000);    // window opens just before the clock wraps
    queue_eval(32'h0000_0020, -10000);   // ... and matures across the wrap
    queue_eval(32'hFFFF_FFFF, -16384);   // most negative duty code, top time
    queue_eval(32'h0000_0000, 16383);    // most positive duty code
    queue_sample(0);                     // falling steps round their size up
    queue_sample(0);
    queue_sample(4095);
    queue_sample(1);
    queue_sample(2048);
    queue_eval(32'd5000, 7777);
    queue_eval(32'd5001, -1);            // tiny negative duty, below min
    wait_for_readings();

    for (int phase = 0; phase < 3; phase++) begin
      send_gap_pct = SEND_GAP[phase];
      take_gap_pct = TAKE_GAP[phase];
      for (int k = 0; k < 5; k++) begin
        programme_registers(reg_setting_t'((k + phase) % 5));
        @(negedge clk);
        queue_random_run(RUN_BEATS);
        wait_for_readings();
      end
    end

    // catch any stray beat after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (readings_due.size() != 0)
      report_mismatch("readings never returned", readings_due.size(), 0);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
